// ===== rtl/core/number_remap_table_chain_resolve_top_assert.svh =====
// ============================================================================
// Assertion macros for the remap table block
// Shared property shorthands, clocked on clk and disabled during reset.
// ============================================================================
`ifndef NUMBER_REMAP_TABLE_CHAIN_RESOLVE_TOP_ASSERT_SVH
`define NUMBER_REMAP_TABLE_CHAIN_RESOLVE_TOP_ASSERT_SVH

// Same-cycle implication.
`define NRT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("remap table assertion failed");

// Next-cycle implication.
`define NRT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("remap table assertion failed");

`endif

// ===== rtl/core/nrt_pkg.sv =====
// ============================================================================
// Remap table package
// Field widths, command and status codes, payload structs and helpers.
// ============================================================================
`default_nettype none

package nrt_pkg;

    localparam int DIGITS_W = 64;
    localparam int LEN_W    = 5;
    localparam int MAP_W    = 4;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_XFORM  = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CYCLE = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [MAP_W-1:0]    map_id;
        logic [DIGITS_W-1:0] key_digits;
        logic [LEN_W-1:0]    key_len;
        logic [DIGITS_W-1:0] value_digits;
        logic [LEN_W-1:0]    value_len;
    } req_t;

    typedef struct packed {
        logic [DIGITS_W-1:0] digits;
        logic [LEN_W-1:0]    len;
        status_t             status;
    } rsp_t;

    // One table slot as held in memory.
    typedef struct packed {
        logic [MAP_W-1:0]    map;
        logic [DIGITS_W-1:0] key;
        logic [LEN_W-1:0]    klen;
        logic [DIGITS_W-1:0] val;
        logic [LEN_W-1:0]    vlen;
    } entry_t;

    // Keeps the nibbles of the first n digits and zeroes the rest.
    function automatic logic [DIGITS_W-1:0] digit_mask(input logic [LEN_W-1:0] n);
        logic [DIGITS_W-1:0] m;
        m = '0;
        for (int i = 0; i < DIGITS_W / 4; i++) begin
            if (LEN_W'(i) < n)
            begin
                m[4*i +: 4] = 4'hF;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nrt_if.sv =====
// ============================================================================
// Remap table channel interfaces
// Valid/ready channels for command and response transactions.
// ============================================================================
`default_nettype none

interface nrt_req_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         cmd;
    logic [nrt_pkg::MAP_W-1:0]          map_id;
    logic [nrt_pkg::DIGITS_W-1:0]       key_digits;
    logic [nrt_pkg::LEN_W-1:0]          key_len;
    logic [nrt_pkg::DIGITS_W-1:0]       value_digits;
    logic [nrt_pkg::LEN_W-1:0]          value_len;

    modport source (output valid, cmd, map_id, key_digits, key_len, value_digits,
                    value_len, input ready);
    modport sink   (input valid, cmd, map_id, key_digits, key_len, value_digits,
                    value_len, output ready);
endinterface

interface nrt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [nrt_pkg::DIGITS_W-1:0]       result_digits;
    logic [nrt_pkg::LEN_W-1:0]          result_len;
    logic [1:0]                         status;

    modport source (output valid, result_digits, result_len, status, input ready);
    modport sink   (input valid, result_digits, result_len, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/nrt_mem.sv =====
// ============================================================================
// Remap table slot memory
// Single-port-write, single-read memory with a registered read, one slot per word.
// ============================================================================
`default_nettype none

module nrt_mem #(
    parameter int ENTRIES = 64,
    parameter int AW      = 6
) (
    input  wire logic            clk,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output nrt_pkg::entry_t      rd_data,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire nrt_pkg::entry_t wr_data
);

    nrt_pkg::entry_t mem [ENTRIES];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nrt_engine.sv =====
// ============================================================================
// Remap table command engine
// Sweeps the slot memory for each lookup and applies insert, erase, clear and
// chain-following transform commands.
// ============================================================================
`default_nettype none

module nrt_engine #(
    parameter int MAX_DIGITS = 16,
    parameter int ENTRIES    = 64,
    parameter int NUM_MAPS   = 16,
    parameter int AW         = 6
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire nrt_pkg::req_t   req,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output nrt_pkg::rsp_t        res,
    output logic                 rd_en,
    output logic [AW-1:0]        rd_addr,
    input  wire nrt_pkg::entry_t rd_data,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output nrt_pkg::entry_t      wr_data
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [nrt_pkg::LEN_W-1:0] MAXL  = nrt_pkg::LEN_W'(MAX_DIGITS);
    localparam logic [8:0]                NMAPS = 9'(NUM_MAPS);
    localparam logic [CW-1:0]             NENT  = CW'(ENTRIES);
    localparam logic [AW-1:0]             LAST  = AW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    nrt_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [nrt_pkg::MAP_W-1:0]       map_reg, map_next;
    logic [nrt_pkg::DIGITS_W-1:0]    key_reg, key_next;
    logic [nrt_pkg::LEN_W-1:0]       klen_reg, klen_next;
    logic [nrt_pkg::DIGITS_W-1:0]    val_reg, val_next;
    logic [nrt_pkg::LEN_W-1:0]       vlen_reg, vlen_next;
    logic [nrt_pkg::DIGITS_W-1:0]    cur_reg, cur_next;
    logic [nrt_pkg::LEN_W-1:0]       clen_reg, clen_next;
    logic [CW-1:0]                   hops_reg, hops_next;
    logic [CW-1:0]                   issue_reg, issue_next;
    logic                            cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]                   cmp_idx_reg, cmp_idx_next;
    logic                            free_ok_reg, free_ok_next;
    logic [AW-1:0]                   free_idx_reg, free_idx_next;
    logic [ENTRIES-1:0]              valid_reg, valid_next;
    nrt_pkg::rsp_t                   res_reg, res_next;

    logic [nrt_pkg::LEN_W-1:0]       in_klen;
    logic [nrt_pkg::LEN_W-1:0]       in_vlen;
    logic                            map_ok;
    logic                            cur_valid;
    logic                            map_hit;
    logic                            key_hit;
    logic                            last;

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // Length clamping and map range check on the incoming command.
    assign in_klen = (req.key_len > MAXL) ? MAXL : req.key_len;
    assign in_vlen = (req.value_len > MAXL) ? MAXL : req.value_len;
    assign map_ok  = ({5'b0, req.map_id} < NMAPS);

    // Compare of the slot that was read in the previous cycle.
    assign cur_valid = valid_reg[cmp_idx_reg];
    assign map_hit   = cur_valid && (rd_data.map == map_reg);
    assign key_hit   = map_hit && (rd_data.klen == clen_reg) && (rd_data.key == cur_reg);
    assign last      = (cmp_idx_reg == LAST);

    // Next-state logic for the sweep and the command decode.
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        map_next      = map_reg;
        key_next      = key_reg;
        klen_next     = klen_reg;
        val_next      = val_reg;
        vlen_next     = vlen_reg;
        cur_next      = cur_reg;
        clen_next     = clen_reg;
        hops_next     = hops_reg;
        issue_next    = issue_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        free_ok_next  = free_ok_reg;
        free_idx_next = free_idx_reg;
        valid_next    = valid_reg;
        res_next      = res_reg;
        rd_en         = 1'b0;
        rd_addr       = issue_reg[AW-1:0];
        wr_en         = 1'b0;
        wr_addr       = cmp_idx_reg;
        wr_data       = '{map: map_reg, key: key_reg, klen: klen_reg,
                          val: val_reg, vlen: vlen_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next     = req.cmd;
                    map_next     = req.map_id;
                    key_next     = req.key_digits & nrt_pkg::digit_mask(in_klen);
                    klen_next    = in_klen;
                    val_next     = req.value_digits & nrt_pkg::digit_mask(in_vlen);
                    vlen_next    = in_vlen;
                    cur_next     = req.key_digits & nrt_pkg::digit_mask(in_klen);
                    clen_next    = in_klen;
                    hops_next    = '0;
                    issue_next   = '0;
                    cmp_vld_next = 1'b0;
                    free_ok_next = 1'b0;
                    res_next     = '{digits: '0, len: '0, status: nrt_pkg::ST_OK};
                    if (map_ok)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                        case (req.cmd)
                            nrt_pkg::CMD_INSERT: res_next.status = nrt_pkg::ST_FULL;
                            nrt_pkg::CMD_ERASE:  res_next.status = nrt_pkg::ST_MISS;
                            nrt_pkg::CMD_XFORM:
                            begin
                                res_next.digits = req.key_digits
                                                  & nrt_pkg::digit_mask(in_klen);
                                res_next.len    = in_klen;
                            end
                            default: res_next.status = nrt_pkg::ST_OK;
                        endcase
                    end
                end
            end

            S_SCAN:
            begin
                rd_en        = (issue_reg < NENT);
                cmp_vld_next = rd_en;
                cmp_idx_next = issue_reg[AW-1:0];
                if (rd_en)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                if (cmp_vld_reg)
                begin
                    // Remember the lowest free slot for a new insert.
                    if (!cur_valid && !free_ok_reg)
                    begin
                        free_ok_next  = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                    case (cmd_reg)
                        nrt_pkg::CMD_CLEAR:
                        begin
                            if (map_hit)
                            begin
                                valid_next[cmp_idx_reg] = 1'b0;
                            end
                            if (last)
                            begin
                                state_next = S_DONE;
                            end
                        end
                        nrt_pkg::CMD_INSERT:
                        begin
                            if (key_hit)
                            begin
                                wr_en                   = 1'b1;
                                valid_next[cmp_idx_reg] = 1'b1;
                                state_next              = S_DONE;
                            end
                            else if (last)
                            begin
                                state_next = S_DONE;
                                if (free_ok_reg)
                                begin
                                    wr_en                    = 1'b1;
                                    wr_addr                  = free_idx_reg;
                                    valid_next[free_idx_reg] = 1'b1;
                                end
                                else if (!cur_valid)
                                begin
                                    wr_en                   = 1'b1;
                                    valid_next[cmp_idx_reg] = 1'b1;
                                end
                                else
                                begin
                                    res_next.status = nrt_pkg::ST_FULL;
                                end
                            end
                        end
                        nrt_pkg::CMD_ERASE:
                        begin
                            if (key_hit)
                            begin
                                valid_next[cmp_idx_reg] = 1'b0;
                                state_next              = S_DONE;
                            end
                            else if (last)
                            begin
                                res_next.status = nrt_pkg::ST_MISS;
                                state_next      = S_DONE;
                            end
                        end
                        default:
                        begin
                            // Transform: follow one hop and restart the sweep.
                            if (key_hit)
                            begin
                                if (hops_reg == NENT)
                                begin
                                    res_next.digits = key_reg;
                                    res_next.len    = klen_reg;
                                    res_next.status = nrt_pkg::ST_CYCLE;
                                    state_next      = S_DONE;
                                end
                                else
                                begin
                                    hops_next    = hops_reg + 1'b1;
                                    cur_next     = rd_data.val;
                                    clen_next    = rd_data.vlen;
                                    issue_next   = '0;
                                    cmp_vld_next = 1'b0;
                                end
                            end
                            else if (last)
                            begin
                                res_next.digits = cur_reg;
                                res_next.len    = clen_reg;
                                state_next      = S_DONE;
                            end
                        end
                    endcase
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            issue_reg   <= '0;
            hops_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            cmp_vld_reg <= cmp_vld_next;
            free_ok_reg <= free_ok_next;
            issue_reg   <= issue_next;
            hops_reg    <= hops_next;
        end
    end

    // Command payload and sweep bookkeeping.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        map_reg      <= map_next;
        key_reg      <= key_next;
        klen_reg     <= klen_next;
        val_reg      <= val_next;
        vlen_reg     <= vlen_next;
        cur_reg      <= cur_next;
        clen_reg     <= clen_next;
        cmp_idx_reg  <= cmp_idx_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/number_remap_table_chain_resolve_top.sv =====
// ============================================================================
// Remap table with chain following: top level
// Commands arrive on req (valid/ready) and each yields exactly one response
// transaction on rsp. Insert, erase, clear and transform share a table of
// ENTRIES slots held in one synchronous memory; valid bits live in flops.
// Every lookup sweeps the memory one slot per cycle through its read port.
// A command on a map outside NUM_MAPS skips the sweep and goes straight to
// its response. One command is in flight at a time; the next is taken once
// the previous one has moved into the response register, even while that
// response still waits. Reset empties the table at once and drops any
// command in flight. When the receiver stalls, the response holds steady and
// the engine parks its next result until the register frees.
// ============================================================================
`default_nettype none

module number_remap_table_chain_resolve_top #(
    parameter int MAX_DIGITS = 16,
    parameter int ENTRIES    = 64,
    parameter int NUM_MAPS   = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    nrt_req_if.sink     req,
    nrt_rsp_if.source   rsp
);

    localparam int AW = $clog2(ENTRIES);

    nrt_pkg::req_t   req_pl;
    nrt_pkg::rsp_t   eng_res;
    nrt_pkg::rsp_t   out_reg;
    nrt_pkg::entry_t rd_data;
    nrt_pkg::entry_t wr_data;
    logic            eng_valid;
    logic            eng_ready;
    logic            out_valid_reg;
    logic            rd_en;
    logic            wr_en;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;

    // Gather the command payload.
    assign req_pl = '{cmd: nrt_pkg::cmd_t'(req.cmd), map_id: req.map_id,
                      key_digits: req.key_digits, key_len: req.key_len,
                      value_digits: req.value_digits, value_len: req.value_len};

    nrt_engine #(
        .MAX_DIGITS (MAX_DIGITS),
        .ENTRIES    (ENTRIES),
        .NUM_MAPS   (NUM_MAPS),
        .AW         (AW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req       (req_pl),
        .res_valid (eng_valid),
        .res_ready (eng_ready),
        .res       (eng_res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    nrt_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Response register: loads when empty or being drained.
    assign eng_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_ready)
        begin
            out_valid_reg <= eng_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_ready && eng_valid)
        begin
            out_reg <= eng_res;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.result_digits = out_reg.digits;
    assign rsp.result_len    = out_reg.len;
    assign rsp.status        = out_reg.status;

endmodule

`default_nettype wire

// ===== rtl/core/nrt_checker.sv =====
// ============================================================================
// Remap table port checker
// Watches the top-level channels and checks response behaviour over time.
// ============================================================================
`default_nettype none

`include "number_remap_table_chain_resolve_top_assert.svh"

module nrt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [63:0] rsp_digits,
    input wire logic [4:0]  rsp_len,
    input wire logic [1:0]  rsp_status
);

    // A stalled response keeps its contents.
    `NRT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digits) && $stable(rsp_len) && $stable(rsp_status))

    // One command at a time: the port closes right after an acceptance.
    `NRT_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready)

    // Full table and missing key carry no number.
    `NRT_ASSERT_IMP(a_fail_empty, rsp_valid && (rsp_status == nrt_pkg::ST_FULL || rsp_status == nrt_pkg::ST_MISS), rsp_digits == 64'd0 && rsp_len == 5'd0)

    // Digit counts never exceed sixteen.
    `NRT_ASSERT_IMP(a_len_range, rsp_valid, rsp_len <= 5'd16)

endmodule

bind number_remap_table_chain_resolve_top nrt_checker u_nrt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_digits (rsp.result_digits),
    .rsp_len    (rsp.result_len),
    .rsp_status (rsp.status)
);

`default_nettype wire
